@@ rtl/ohlcv_pkg.sv @@
// Shared widths, types and helpers for the OHLCV time bar aggregator.
`default_nettype none
package ohlcv_pkg;

	localparam int unsigned PRICE_W = 48;
	localparam int unsigned TIME_W  = 48;
	localparam int unsigned END_W   = 49;
	localparam int unsigned PER_W   = 32;
	localparam int unsigned ALU_W   = 49;
	localparam int unsigned CNT_W   = 6;

	localparam logic [PER_W-1:0] PERIOD_RESET = 32'd60000;
	localparam logic [CNT_W-1:0] DIV_LAST     = 6'd47;

	typedef struct packed {
		logic [TIME_W-1:0]  start_ms;
		logic [END_W-1:0]   end_ms;
		logic [PRICE_W-1:0] open;
		logic [PRICE_W-1:0] high;
		logic [PRICE_W-1:0] low;
		logic [PRICE_W-1:0] close;
		logic [PRICE_W-1:0] volume;
	} bar_t;

	typedef struct packed {
		logic valid;
		bar_t bar;
	} emit_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             carry;
	} alu_rsp_t;

	function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] per);
		eff_period = (per == '0) ? {{(PER_W-1){1'b0}}, 1'b1} : per;
	endfunction

endpackage
`default_nettype wire

@@ rtl/ohlcv_alu.sv @@
// Shared add/subtract unit: sum or difference with carry out.
`default_nettype none
module ohlcv_alu (
	input  ohlcv_pkg::alu_req_t req,
	output ohlcv_pkg::alu_rsp_t rsp
);

	logic [ohlcv_pkg::ALU_W-1:0] b_op;
	logic [ohlcv_pkg::ALU_W:0]   sum;

	assign b_op = req.sub ? ~req.b : req.b;
	assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{ohlcv_pkg::ALU_W{1'b0}}, req.sub};
	assign rsp.res   = sum[ohlcv_pkg::ALU_W-1:0];
	assign rsp.carry = sum[ohlcv_pkg::ALU_W];

endmodule
`default_nettype wire

@@ rtl/ohlcv_core.sv @@
// Tick sequencer and open-bar state around the shared add/subtract unit.
`default_nettype none
module ohlcv_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [ohlcv_pkg::PRICE_W-1:0] tick_price,
	input  wire [ohlcv_pkg::PRICE_W-1:0] tick_volume,
	input  wire [ohlcv_pkg::TIME_W-1:0]  tick_time_ms,
	input  wire [ohlcv_pkg::PER_W-1:0]   period,
	input  wire                          out_free,
	output ohlcv_pkg::emit_t             emit
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CMP_T  = 4'd1;
	localparam logic [3:0] ST_CMP_HI = 4'd2;
	localparam logic [3:0] ST_CMP_LO = 4'd3;
	localparam logic [3:0] ST_ADD_V  = 4'd4;
	localparam logic [3:0] ST_ROLL   = 4'd5;
	localparam logic [3:0] ST_DIV    = 4'd6;
	localparam logic [3:0] ST_START  = 4'd7;
	localparam logic [3:0] ST_END    = 4'd8;

	logic [3:0]                    state_q;
	logic [ohlcv_pkg::CNT_W-1:0]   cnt_q;
	logic [ohlcv_pkg::PER_W-1:0]   rem_q;
	logic [ohlcv_pkg::PER_W:0]     rem_sh;
	logic [ohlcv_pkg::PER_W-1:0]   per_eff;
	logic                          started_q;
	logic [ohlcv_pkg::PRICE_W-1:0] price_q;
	logic [ohlcv_pkg::PRICE_W-1:0] vol_q;
	logic [ohlcv_pkg::TIME_W-1:0]  time_q;
	ohlcv_pkg::bar_t               cur_q;
	ohlcv_pkg::alu_req_t           alu_req;
	ohlcv_pkg::alu_rsp_t           alu_rsp;

	ohlcv_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign per_eff  = ohlcv_pkg::eff_period(period);
	assign rem_sh   = {rem_q, time_q[cnt_q]};
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_CMP_T: begin
				alu_req.a   = {1'b0, time_q};
				alu_req.b   = cur_q.end_ms;
				alu_req.sub = 1'b1;
			end
			ST_CMP_HI: begin
				alu_req.a   = {1'b0, cur_q.high};
				alu_req.b   = {1'b0, price_q};
				alu_req.sub = 1'b1;
			end
			ST_CMP_LO: begin
				alu_req.a   = {1'b0, price_q};
				alu_req.b   = {1'b0, cur_q.low};
				alu_req.sub = 1'b1;
			end
			ST_ADD_V: begin
				alu_req.a   = {1'b0, cur_q.volume};
				alu_req.b   = {1'b0, vol_q};
				alu_req.sub = 1'b0;
			end
			ST_DIV: begin
				alu_req.a   = {{(ohlcv_pkg::ALU_W-ohlcv_pkg::PER_W-1){1'b0}}, rem_sh};
				alu_req.b   = {{(ohlcv_pkg::ALU_W-ohlcv_pkg::PER_W){1'b0}}, per_eff};
				alu_req.sub = 1'b1;
			end
			ST_START: begin
				alu_req.a   = {1'b0, time_q};
				alu_req.b   = {{(ohlcv_pkg::ALU_W-ohlcv_pkg::PER_W){1'b0}}, rem_q};
				alu_req.sub = 1'b1;
			end
			ST_END: begin
				alu_req.a   = {1'b0, cur_q.start_ms};
				alu_req.b   = {{(ohlcv_pkg::ALU_W-ohlcv_pkg::PER_W){1'b0}}, per_eff};
				alu_req.sub = 1'b0;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	always_comb begin
		emit.valid = (state_q == ST_ROLL) && out_free;
		emit.bar   = cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			cnt_q     <= '0;
			cur_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= started_q ? ST_CMP_T : ST_DIV;
						cnt_q   <= ohlcv_pkg::DIV_LAST;
					end
				end
				ST_CMP_T: begin
					state_q <= alu_rsp.carry ? ST_ROLL : ST_CMP_HI;
				end
				ST_CMP_HI: begin
					if (!alu_rsp.carry) begin
						cur_q.high <= price_q;
					end
					cur_q.close <= price_q;
					state_q     <= ST_CMP_LO;
				end
				ST_CMP_LO: begin
					if (!alu_rsp.carry) begin
						cur_q.low <= price_q;
					end
					state_q <= ST_ADD_V;
				end
				ST_ADD_V: begin
					cur_q.volume <= alu_rsp.res[ohlcv_pkg::PRICE_W] ? '1
						: alu_rsp.res[ohlcv_pkg::PRICE_W-1:0];
					state_q <= ST_IDLE;
				end
				ST_ROLL: begin
					if (out_free) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_START;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_START: begin
					cur_q.start_ms <= alu_rsp.res[ohlcv_pkg::TIME_W-1:0];
					state_q        <= ST_END;
				end
				ST_END: begin
					cur_q.end_ms <= alu_rsp.res;
					cur_q.open   <= price_q;
					cur_q.high   <= price_q;
					cur_q.low    <= price_q;
					cur_q.close  <= price_q;
					cur_q.volume <= vol_q;
					started_q    <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			price_q <= tick_price;
			vol_q   <= tick_volume;
			time_q  <= tick_time_ms;
			rem_q   <= '0;
		end else if (state_q == ST_ROLL) begin
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= alu_rsp.carry ? alu_rsp.res[ohlcv_pkg::PER_W-1:0]
				: rem_sh[ohlcv_pkg::PER_W-1:0];
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("bar transfer issued while output slot busy");

	a_emit_div: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |=> state_q == ST_DIV)
		else $error("closed bar not followed by realignment");

	a_low_high: assert property (@(posedge clk) disable iff (!arst_n)
		(started_q && state_q == ST_IDLE) |-> cur_q.low <= cur_q.high)
		else $error("bar low above bar high");

	a_end_after: assert property (@(posedge clk) disable iff (!arst_n)
		(started_q && state_q == ST_IDLE) |->
		cur_q.end_ms > {1'b0, cur_q.start_ms})
		else $error("bar end not after bar start");

endmodule
`default_nettype wire

@@ rtl/ohlcv_time_bar_aggregator.sv @@
// Top level: OHLCV time bar aggregator with period register and result register.
// A tick inside the open bar runs the time, high, low and volume steps in turn.
// A tick that closes a bar waits for a free result register, then like the first tick
// runs the bit-serial remainder loop (48 steps) on the shared unit to align the bar.
// The closed bar enters the result register after the time compare, once it is free.
// Reset (arst_n low) clears the open bar, drops any held result, period 60000 ms.
`default_nettype none
module ohlcv_time_bar_aggregator (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [ohlcv_pkg::PER_W-1:0]   period_length_ms,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [ohlcv_pkg::PRICE_W-1:0] tick_price,
	input  wire [ohlcv_pkg::PRICE_W-1:0] tick_volume,
	input  wire [ohlcv_pkg::TIME_W-1:0]  tick_time_ms,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [ohlcv_pkg::TIME_W-1:0]  bar_open_time,
	output logic [ohlcv_pkg::END_W-1:0]   bar_close_time,
	output logic [ohlcv_pkg::PRICE_W-1:0] bar_open,
	output logic [ohlcv_pkg::PRICE_W-1:0] bar_high,
	output logic [ohlcv_pkg::PRICE_W-1:0] bar_low,
	output logic [ohlcv_pkg::PRICE_W-1:0] bar_close,
	output logic [ohlcv_pkg::PRICE_W-1:0] bar_volume
);

	logic [ohlcv_pkg::PER_W-1:0] period_q;
	logic                        out_valid_q;
	logic                        out_free;
	ohlcv_pkg::bar_t             bar_q;
	ohlcv_pkg::emit_t            emit;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	ohlcv_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.tick_price  (tick_price),
		.tick_volume (tick_volume),
		.tick_time_ms(tick_time_ms),
		.period      (period_q),
		.out_free    (out_free),
		.emit        (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= ohlcv_pkg::PERIOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				period_q <= period_length_ms;
			end
			if (emit.valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			bar_q <= emit.bar;
		end
	end

	assign out_valid      = out_valid_q;
	assign bar_open_time  = bar_q.start_ms;
	assign bar_close_time = bar_q.end_ms;
	assign bar_open       = bar_q.open;
	assign bar_high       = bar_q.high;
	assign bar_low        = bar_q.low;
	assign bar_close      = bar_q.close;
	assign bar_volume     = bar_q.volume;

endmodule
`default_nettype wire
